// ----- rtl/pair_potential_energy_accumulator_assert.svh -----
// ----------------------------------------------------------------------------
// Pair potential energy accumulator - assertion macros
// Shorthand for the concurrent checks at the end of the top level.
// ----------------------------------------------------------------------------
`ifndef PAIR_POTENTIAL_ENERGY_ACCUMULATOR_ASSERT_SVH
`define PAIR_POTENTIAL_ENERGY_ACCUMULATOR_ASSERT_SVH

// condition implies consequence in the same cycle
`define PPEA_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// condition implies consequence in the next cycle
`define PPEA_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ----- rtl/ppea_pkg.sv -----
// ----------------------------------------------------------------------------
// ppea_pkg
// Shared types, constants and helpers of the pair energy accumulator.
// ----------------------------------------------------------------------------
package ppea_pkg;

	// species codes wrap at this count
	localparam int SPECIES_COUNT = 4;
	localparam int DIAM_COUNT    = 4;
	localparam int QUEUE_DEPTH   = 2;
	localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

	localparam logic [63:0] SUM_CAP  = 64'h7FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] CAP_QTR  = 64'h1FFF_FFFF_FFFF_FFFF;
	localparam logic [63:0] HALF_Q32 = 64'h0000_0000_8000_0000;
	// 33.75 * ln 2 in Q32.32
	localparam logic [63:0] FENE_K   = 64'd100475250924;

	// configuration register indexes
	typedef enum logic [2:0] {
		CFG_BOX   = 3'd0,
		CFG_DIAM0 = 3'd1,
		CFG_DIAM1 = 3'd2,
		CFG_DIAM2 = 3'd3,
		CFG_DIAM3 = 3'd4
	} cfg_idx_t;

	// pair kind
	localparam logic CMD_WCA  = 1'b0;
	localparam logic CMD_FENE = 1'b1;

	// one classified pair between front and back
	typedef struct packed {
		logic        cmd;
		logic        last;
		logic [31:0] s;
		logic [63:0] r2;
	} pair_t;

	typedef struct packed {
		logic  push;
		pair_t pair;
	} q_wr_t;

	typedef struct packed {
		logic  valid;
		pair_t pair;
	} q_rd_t;

	// species code modulo SPECIES_COUNT
	function automatic logic [1:0] species_wrap(input logic [1:0] code);
		logic [2:0] v;
		v = {1'b0, code};
		for (int i = 0; i < 3; i++) begin
			if (v >= 3'(SPECIES_COUNT)) begin
				v = v - 3'(SPECIES_COUNT);
			end
		end
		return v[1:0];
	endfunction

endpackage

// ----- rtl/pair_potential_energy_accumulator.sv -----
// ----------------------------------------------------------------------------
// pair_potential_energy_accumulator
// WCA / FENE pair energy summed per particle in Q32.32, with saturation flag.
// ----------------------------------------------------------------------------
//  channel  | dir | signals                        | word
//  ---------+-----+--------------------------------+------------------------------
//  s_       | in  | tvalid tready tdata tuser tlast| one pair, tlast ends particle
//  m_       | out | tvalid tready tdata            | particle total and flag
//  cfg_     | in  | we index wdata                 | box length, four diameters
//
//  Front: a 33-step remainder divider per axis, then fold and square, for each pair.
//  Back: WCA uses a 96-step divider and three multiplies; FENE uses two log2 passes,
//  each a shift to the leading one followed by 32 squarings.
//  A two-word queue lets the front take the next pair while the back works.
//  The result register holds its word while m_tready is low; a new last pair waits.
//  arst_n clears control, the running sum and the flag; configuration resets too.
`include "pair_potential_energy_accumulator_assert.svh"

module pair_potential_energy_accumulator import ppea_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         s_tvalid,
	output logic         s_tready,
	// x_self, y_self, z_self, species_self, x_other, y_other, z_other,
	// species_other, zero pad
	input  logic [199:0] s_tdata,
	// cmd
	input  logic [0:0]   s_tuser,
	input  logic         s_tlast,
	output logic         m_tvalid,
	input  logic         m_tready,
	// energy_total, saturated
	output logic [63:0]  m_tdata,
	input  logic         cfg_we,
	input  logic [2:0]   cfg_index,
	input  logic [30:0]  cfg_wdata
);

	logic [30:0]                 box_q;
	logic [DIAM_COUNT-1:0][30:0] diam_q;
	q_wr_t                       q_wr;
	q_rd_t                       q_rd;
	logic                        q_full;
	logic                        pop;

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			box_q  <= 31'd655360;
			diam_q <= {DIAM_COUNT{31'd65536}};
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_BOX:   box_q     <= cfg_wdata;
				CFG_DIAM0: diam_q[0] <= cfg_wdata;
				CFG_DIAM1: diam_q[1] <= cfg_wdata;
				CFG_DIAM2: diam_q[2] <= cfg_wdata;
				CFG_DIAM3: diam_q[3] <= cfg_wdata;
				default: ;
			endcase
		end
	end

	ppea_front u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.s_tlast    (s_tlast),
		.box_length (box_q),
		.diam       (diam_q),
		.q_full     (q_full),
		.q_wr       (q_wr)
	);

	ppea_queue u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.q_wr   (q_wr),
		.pop    (pop),
		.full   (q_full),
		.q_rd   (q_rd)
	);

	ppea_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_rd     (q_rd),
		.pop      (pop),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// checks
	`PPEA_ASSERT_NOW(a_push_room, q_wr.push, !q_full, "front pushed into a full queue")
	`PPEA_ASSERT_NOW(a_pop_data, pop, q_rd.valid, "back popped an empty queue")
	`PPEA_ASSERT_NEXT(a_front_busy, s_tvalid && s_tready, !s_tready, "front took a word while busy")

endmodule

// ----- rtl/ppea_front.sv -----
// ----------------------------------------------------------------------------
// ppea_front
// Takes a pair word, folds each axis by minimum image, forms r2 and sigma sum.
// ----------------------------------------------------------------------------
module ppea_front import ppea_pkg::*; (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         s_tvalid,
	output logic                         s_tready,
	input  logic [199:0]                 s_tdata,
	input  logic [0:0]                   s_tuser,
	input  logic                         s_tlast,
	input  logic [30:0]                  box_length,
	input  logic [DIAM_COUNT-1:0][30:0]  diam,
	input  logic                         q_full,
	output q_wr_t                        q_wr
);

	typedef enum logic [5:0] {
		F_IDLE = 6'b000001,
		F_LOAD = 6'b000010,
		F_DIV  = 6'b000100,
		F_FOLD = 6'b001000,
		F_SQ   = 6'b010000,
		F_PUSH = 6'b100000
	} fstate_t;

	fstate_t       state_q;
	logic [195:0]  in_q;
	logic          cmd_q;
	logic          last_q;
	logic [1:0]    axis_q;
	logic [32:0]   num_q;
	logic [30:0]   rem_q;
	logic [5:0]    cnt_q;
	logic [30:0]   fold_q;
	logic [63:0]   r2_q;

	logic [30:0]   len;
	logic [31:0]   pos_self;
	logic [31:0]   pos_other;
	logic [32:0]   diff;
	logic [32:0]   dist_abs;
	logic [31:0]   rem_t;
	logic [61:0]   sq;
	logic [31:0]   sigma_sum;

	// zero box acts as one raw unit
	assign len = (box_length == '0) ? 31'd1 : box_length;

	// axis select
	always_comb begin
		case (axis_q)
			2'd0: begin
				pos_self  = in_q[31:0];
				pos_other = in_q[129:98];
			end
			2'd1: begin
				pos_self  = in_q[63:32];
				pos_other = in_q[161:130];
			end
			2'd2: begin
				pos_self  = in_q[95:64];
				pos_other = in_q[193:162];
			end
			default: begin
				pos_self  = in_q[31:0];
				pos_other = in_q[129:98];
			end
		endcase
	end

	assign diff     = {pos_self[31], pos_self} - {pos_other[31], pos_other};
	assign dist_abs = diff[32] ? (33'd0 - diff) : diff;
	assign rem_t    = {rem_q, num_q[32]};
	assign sq       = fold_q * fold_q;
	assign sigma_sum = {1'b0, diam[species_wrap(in_q[97:96])]}
		+ {1'b0, diam[species_wrap(in_q[195:194])]};

	assign s_tready     = (state_q == F_IDLE);
	assign q_wr.push    = (state_q == F_PUSH) && !q_full;
	assign q_wr.pair    = '{cmd: cmd_q, last: last_q, s: sigma_sum, r2: r2_q};

	// control sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			axis_q  <= '0;
			cnt_q   <= '0;
		end else begin
			case (state_q)
				F_IDLE: if (s_tvalid) begin
					axis_q  <= '0;
					state_q <= F_LOAD;
				end
				F_LOAD: begin
					cnt_q   <= 6'd32;
					state_q <= F_DIV;
				end
				F_DIV: begin
					if (cnt_q == '0) state_q <= F_FOLD;
					else cnt_q <= cnt_q - 6'd1;
				end
				F_FOLD: state_q <= F_SQ;
				F_SQ: begin
					if (axis_q == 2'd2) begin
						state_q <= F_PUSH;
					end else begin
						axis_q  <= axis_q + 2'd1;
						state_q <= F_LOAD;
					end
				end
				F_PUSH: if (!q_full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

	// datapath: remainder of |d| by the box, then fold and square
	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: if (s_tvalid) begin
				in_q   <= s_tdata[195:0];
				cmd_q  <= s_tuser[0];
				last_q <= s_tlast;
				r2_q   <= '0;
			end
			F_LOAD: begin
				num_q <= dist_abs;
				rem_q <= '0;
			end
			F_DIV: begin
				num_q <= {num_q[31:0], 1'b0};
				if (rem_t >= {1'b0, len}) rem_q <= 31'(rem_t - {1'b0, len});
				else rem_q <= rem_t[30:0];
			end
			F_FOLD: begin
				// halves round up: take the far side
				if ({rem_q, 1'b0} >= {1'b0, len}) fold_q <= len - rem_q;
				else fold_q <= rem_q;
			end
			F_SQ: r2_q <= r2_q + {2'b0, sq};
			default: ;
		endcase
	end

endmodule

// ----- rtl/ppea_queue.sv -----
// ----------------------------------------------------------------------------
// ppea_queue
// Small register queue between the front and back parts.
// ----------------------------------------------------------------------------
module ppea_queue import ppea_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  q_wr_t q_wr,
	input  logic  pop,
	output logic  full,
	output q_rd_t q_rd
);

	pair_t              mem_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  count_q;

	assign full       = (count_q == QCNT_W'(QUEUE_DEPTH));
	assign q_rd.valid = (count_q != '0);
	assign q_rd.pair  = mem_q[rd_ptr_q];

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (q_wr.push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (q_wr.push && !pop) count_q <= count_q + 1'b1;
			else if (pop && !q_wr.push) count_q <= count_q - 1'b1;
		end
	end

	// entry store
	always_ff @(posedge clk) begin
		if (q_wr.push) mem_q[wr_ptr_q] <= q_wr.pair;
	end

endmodule

// ----- rtl/ppea_back.sv -----
// ----------------------------------------------------------------------------
// ppea_back
// Evaluates the WCA or FENE term with shared multi-cycle units and sums it.
// ----------------------------------------------------------------------------
module ppea_back import ppea_pkg::*; (
	input  logic        clk,
	input  logic        arst_n,
	input  q_rd_t       q_rd,
	output logic        pop,
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [63:0] m_tdata
);

	typedef enum logic [7:0] {
		B_IDLE  = 8'b00000001,
		B_PLAN  = 8'b00000010,
		B_DIV   = 8'b00000100,
		B_MUL   = 8'b00001000,
		B_LNORM = 8'b00010000,
		B_LSQ   = 8'b00100000,
		B_LFIX  = 8'b01000000,
		B_ACC   = 8'b10000000
	} bstate_t;

	bstate_t      state_q;
	logic         cmd_q;
	logic         last_q;
	logic [63:0]  s2_q;
	logic [63:0]  r2_q;
	logic [2:0]   step_q;
	logic [63:0]  a_q;
	logic [63:0]  y_q;
	logic [63:0]  term_q;
	logic         tsat_q;
	logic [63:0]  sum_q;
	logic         ovf_q;
	logic         out_valid_q;
	logic [63:0]  out_data_q;
	// multiply unit
	logic [63:0]  ma_q;
	logic [63:0]  mb_q;
	logic [127:0] acc_q;
	logic [63:0]  pp_q;
	logic [2:0]   pidx_q;
	// divide unit
	logic [95:0]  n_q;
	logic [63:0]  den_q;
	logic [63:0]  drem_q;
	logic [6:0]   dcnt_q;
	// log2 unit
	logic [67:0]  v_q;
	logic [6:0]   e_q;
	logic [31:0]  m_q;
	logic [31:0]  fr_q;
	logic [4:0]   lcnt_q;

	logic [31:0]  mul_x;
	logic [31:0]  mul_y;
	logic [63:0]  prod;
	logic [127:0] acc_add;
	logic [127:0] acc_next;
	logic [64:0]  div_t;
	logic         div_bit;
	logic [95:0]  n_next;
	logic [67:0]  a_wide;
	logic [67:0]  b_wide;
	logic [32:0]  sq_t;
	logic [31:0]  fr_next;
	logic [63:0]  log_diff;
	logic [63:0]  y_less_half;
	logic [63:0]  sum_raw;
	logic         add_sat;
	logic         ovf_next;
	logic         out_free;

	assign pop      = (state_q == B_IDLE) && q_rd.valid;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;
	assign out_free = !out_valid_q || m_tready;

	// shared 32x32 multiplier
	always_comb begin
		case (state_q)
			B_MUL: begin
				case (pidx_q)
					3'd0: begin
						mul_x = ma_q[31:0];
						mul_y = mb_q[31:0];
					end
					3'd1: begin
						mul_x = ma_q[31:0];
						mul_y = mb_q[63:32];
					end
					3'd2: begin
						mul_x = ma_q[63:32];
						mul_y = mb_q[31:0];
					end
					default: begin
						mul_x = ma_q[63:32];
						mul_y = mb_q[63:32];
					end
				endcase
			end
			B_LSQ: begin
				mul_x = m_q;
				mul_y = m_q;
			end
			default: begin
				mul_x = q_rd.pair.s;
				mul_y = q_rd.pair.s;
			end
		endcase
	end
	assign prod = mul_x * mul_y;

	// partial product placement, one product behind the multiplier
	always_comb begin
		case (pidx_q)
			3'd1:    acc_add = {64'd0, pp_q};
			3'd2:    acc_add = {32'd0, pp_q, 32'd0};
			3'd3:    acc_add = {32'd0, pp_q, 32'd0};
			3'd4:    acc_add = {pp_q, 64'd0};
			default: acc_add = '0;
		endcase
	end
	assign acc_next = acc_q + acc_add;

	// one restoring division step
	assign div_t   = {drem_q, n_q[95]};
	assign div_bit = (div_t >= {1'b0, den_q});
	assign n_next  = {n_q[94:0], div_bit};

	// FENE bounds: A = 9 s^2, B = 16 r2
	assign a_wide = {1'b0, s2_q, 3'd0} + {4'd0, s2_q};
	assign b_wide = {r2_q, 4'd0};

	// log2 squaring renormalise
	assign sq_t    = pp_q[63:31];
	assign fr_next = {fr_q[30:0], sq_t[32]};

	assign log_diff    = (a_q > y_q) ? (a_q - y_q) : 64'd0;
	assign y_less_half = y_q - HALF_Q32;

	// saturating sum
	assign sum_raw  = sum_q + term_q;
	assign add_sat  = sum_raw[63];
	assign ovf_next = ovf_q || tsat_q || add_sat;

	// control and datapath
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= B_IDLE;
			sum_q       <= '0;
			ovf_q       <= 1'b0;
			out_valid_q <= 1'b0;
			step_q      <= '0;
			pidx_q      <= '0;
			dcnt_q      <= '0;
			lcnt_q      <= '0;
			tsat_q      <= 1'b0;
		end else begin
			// result word leaves; a last pair in B_ACC loads the next one itself
			if (out_valid_q && m_tready && !(state_q == B_ACC && last_q)) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				B_IDLE: if (q_rd.valid) begin
					cmd_q   <= q_rd.pair.cmd;
					last_q  <= q_rd.pair.last;
					r2_q    <= q_rd.pair.r2;
					s2_q    <= prod;
					step_q  <= '0;
					tsat_q  <= 1'b0;
					state_q <= B_PLAN;
				end
				B_PLAN: begin
					if (cmd_q == CMD_WCA) begin
						case (step_q)
							3'd0: begin
								if (r2_q == '0) begin
									term_q  <= SUM_CAP;
									tsat_q  <= 1'b1;
									state_q <= B_ACC;
								end else begin
									n_q     <= {s2_q, 32'd0};
									den_q   <= {r2_q[61:0], 2'b00};
									drem_q  <= '0;
									dcnt_q  <= 7'd95;
									state_q <= B_DIV;
								end
							end
							3'd1: begin
								a_q     <= y_q;
								ma_q    <= y_q;
								mb_q    <= y_q;
								acc_q   <= '0;
								pidx_q  <= '0;
								state_q <= B_MUL;
							end
							3'd2: begin
								ma_q    <= y_q;
								mb_q    <= a_q;
								acc_q   <= '0;
								pidx_q  <= '0;
								state_q <= B_MUL;
							end
							3'd3: begin
								if (y_q <= HALF_Q32) begin
									term_q  <= '0;
									state_q <= B_ACC;
								end else begin
									ma_q    <= y_less_half;
									mb_q    <= y_less_half;
									acc_q   <= '0;
									pidx_q  <= '0;
									state_q <= B_MUL;
								end
							end
							default: begin
								if (y_q > CAP_QTR) begin
									term_q <= SUM_CAP;
									tsat_q <= 1'b1;
								end else begin
									term_q <= {y_q[61:0], 2'b00};
								end
								state_q <= B_ACC;
							end
						endcase
					end else begin
						case (step_q)
							3'd0: begin
								if (b_wide > a_wide) begin
									term_q  <= '0;
									state_q <= B_ACC;
								end else if (b_wide == a_wide) begin
									// bond limit reached
									term_q  <= SUM_CAP;
									tsat_q  <= 1'b1;
									state_q <= B_ACC;
								end else begin
									v_q     <= a_wide;
									e_q     <= 7'd67;
									state_q <= B_LNORM;
								end
							end
							3'd1: begin
								a_q     <= y_q;
								v_q     <= a_wide - b_wide;
								e_q     <= 7'd67;
								state_q <= B_LNORM;
							end
							3'd2: begin
								ma_q    <= FENE_K;
								mb_q    <= log_diff;
								acc_q   <= '0;
								pidx_q  <= '0;
								state_q <= B_MUL;
							end
							default: begin
								term_q  <= y_q;
								state_q <= B_ACC;
							end
						endcase
					end
				end
				B_DIV: begin
					n_q    <= n_next;
					drem_q <= div_bit ? 64'(div_t - {1'b0, den_q}) : div_t[63:0];
					if (dcnt_q == '0) begin
						if (n_next[95:63] != '0) begin
							y_q    <= SUM_CAP;
							tsat_q <= 1'b1;
						end else begin
							y_q <= n_next[63:0];
						end
						step_q  <= step_q + 3'd1;
						state_q <= B_PLAN;
					end else begin
						dcnt_q <= dcnt_q - 7'd1;
					end
				end
				B_MUL: begin
					pp_q  <= prod;
					acc_q <= acc_next;
					if (pidx_q == 3'd4) begin
						if (acc_next[127:95] != '0) begin
							y_q    <= SUM_CAP;
							tsat_q <= 1'b1;
						end else begin
							y_q <= {1'b0, acc_next[94:32]};
						end
						step_q  <= step_q + 3'd1;
						state_q <= B_PLAN;
					end else begin
						pidx_q <= pidx_q + 3'd1;
					end
				end
				B_LNORM: begin
					// leading one to the top, one bit a cycle
					if (v_q[67]) begin
						m_q     <= v_q[67:36];
						fr_q    <= '0;
						lcnt_q  <= 5'd31;
						state_q <= B_LSQ;
					end else begin
						v_q <= {v_q[66:0], 1'b0};
						e_q <= e_q - 7'd1;
					end
				end
				B_LSQ: begin
					pp_q    <= prod;
					state_q <= B_LFIX;
				end
				B_LFIX: begin
					m_q  <= sq_t[32] ? sq_t[32:1] : sq_t[31:0];
					fr_q <= fr_next;
					if (lcnt_q == '0) begin
						y_q     <= {25'd0, e_q, fr_next};
						step_q  <= step_q + 3'd1;
						state_q <= B_PLAN;
					end else begin
						lcnt_q  <= lcnt_q - 5'd1;
						state_q <= B_LSQ;
					end
				end
				B_ACC: begin
					if (!last_q) begin
						sum_q   <= add_sat ? SUM_CAP : sum_raw;
						ovf_q   <= ovf_next;
						state_q <= B_IDLE;
					end else if (out_free) begin
						out_data_q  <= {ovf_next, (add_sat ? SUM_CAP[62:0] : sum_raw[62:0])};
						out_valid_q <= 1'b1;
						sum_q       <= '0;
						ovf_q       <= 1'b0;
						state_q     <= B_IDLE;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule
